// ----- rtl/dvsp_pkg.sv -----
`default_nettype none

package dvsp_pkg;

  // widths of the sample path and the code path
  localparam int SAMPLE_W = 16;
  localparam int DELTA_W  = 17;
  localparam int CODE_W   = 21;
  localparam int LEN_W    = 5;
  localparam int ACC_W    = 28;
  localparam int CNT_W    = 5;
  localparam int BYTE_W   = 8;

  // code lengths for zero to three extension groups
  localparam logic [LEN_W-1:0] LEN_BASE  = LEN_W'(6);
  localparam logic [LEN_W-1:0] LEN_GROUP = LEN_W'(5);

  // one coded value waiting for the byte packer
  typedef struct packed {
    logic [CODE_W-1:0] bits;
    logic [LEN_W-1:0]  len;
    logic              flush;
  } code_t;

  // variable length code of a 17-bit signed value, right aligned
  function automatic code_t make_code(input logic [DELTA_W-1:0] v, input logic flush);
    code_t       c;
    logic [1:0]  groups;
    logic        sign;
    sign = v[DELTA_W-1];
    // number of 4-bit groups needed above the low 5 bits
    if (v[DELTA_W-1:12] != {5{sign}}) begin
      groups = 2'd3;
    end else if (v[DELTA_W-1:8] != {9{sign}}) begin
      groups = 2'd2;
    end else if (v[DELTA_W-1:4] != {13{sign}}) begin
      groups = 2'd1;
    end else begin
      groups = 2'd0;
    end
    c.bits      = '0;
    c.bits[4:0] = v[4:0];
    for (int k = 0; k < 3; k++) begin
      if (k < int'(groups)) begin
        c.bits[6 + 5*k +: 5] = {1'b1, v[5 + 4*k +: 4]};
      end
    end
    c.len   = LEN_W'(LEN_BASE + LEN_W'(groups) * LEN_GROUP);
    c.flush = flush;
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/delta_varlen_sample_packer_core.sv -----
`default_nettype none

// Delta coder and byte packer for up to NUM_CHANNELS interleaved sample streams.
// Each input transaction carries a signed sample, its channel and an end flag;
// the first sample of a channel is coded as is, later ones as the 17-bit
// difference from that channel's previous sample, in a 6/11/16/21-bit
// continuation code packed MSB first into bytes. The last byte an input causes
// has tlast set; on end of stream a partial byte is flushed zero padded with
// tuser set, and all channel history is dropped. Previous samples live in a
// one-port synchronous RAM read and written at input accept, so the front end
// takes one transaction per clock while stage b can move on. The byte packer
// sends one byte per clock while the output register is free, and loads the
// next code in the same clock as the final byte of the current one. From input
// accept to the first byte, a sample passes the stage b and stage c registers,
// the packer accumulator and the output register.
module delta_varlen_sample_packer_core
  import dvsp_pkg::*;
#(
  parameter int NUM_CHANNELS = 6
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // sample[15:0], channel[18:16], zero fill
  input  wire logic        s_axis_tlast,   // end_of_stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // out_byte[7:0]
  output logic             m_axis_tlast,   // last_of_run
  output logic             m_axis_tuser    // padded_final
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // input fields
  logic [SAMPLE_W-1:0] in_sample;
  logic [2:0]          in_channel;
  logic [CH_W-1:0]     in_addr;
  logic                in_range;
  logic                in_accept;

  assign in_sample  = s_axis_tdata[15:0];
  assign in_channel = s_axis_tdata[18:16];
  assign in_addr    = CH_W'(in_channel);
  assign in_range   = 7'(in_channel) < 7'(NUM_CHANNELS);
  assign in_accept  = s_axis_tvalid && s_axis_tready;

  // previous sample ram and per-channel seen bits
  logic [SAMPLE_W-1:0]     prev_mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] seen;

  // stage b: ram read data and the registered input
  logic                b_valid;
  logic [SAMPLE_W-1:0] b_sample;
  logic [SAMPLE_W-1:0] b_prev;
  logic                b_use_delta;
  logic                b_end;

  // stage c: coded value
  logic  c_valid;
  code_t c_code;

  // packer state
  logic [ACC_W-1:0] acc;
  logic [CNT_W-1:0] total;
  logic             flush;

  logic b_move;
  logic load;

  assign s_axis_tready = !b_valid || b_move;

  // ram: read old value and, for an in-range channel, write the new sample in the accept cycle
  always_ff @(posedge clk) begin
    if (in_accept) begin
      b_prev <= prev_mem[in_addr];
      if (in_range) begin
        prev_mem[in_addr] <= in_sample;
      end
    end
  end

  // seen bits, cleared on reset and on end of stream
  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (in_accept) begin
      if (s_axis_tlast) begin
        seen <= '0;
      end else if (in_range) begin
        seen[in_addr] <= 1'b1;
      end
    end
  end

  // stage b registers
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (in_accept) begin
      b_valid <= 1'b1;
    end else if (b_move) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      b_sample    <= in_sample;
      b_use_delta <= in_range && seen[in_addr];
      b_end       <= s_axis_tlast;
    end
  end

  // difference or plain sample, then the code
  logic [DELTA_W-1:0] b_value;
  code_t              b_code;

  always_comb begin
    if (b_use_delta) begin
      b_value = {b_sample[SAMPLE_W-1], b_sample} - {b_prev[SAMPLE_W-1], b_prev};
    end else begin
      b_value = {b_sample[SAMPLE_W-1], b_sample};
    end
    b_code = make_code(b_value, b_end);
  end

  assign b_move = b_valid && (!c_valid || load);

  // stage c registers
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (b_move) begin
      c_valid <= 1'b1;
    end else if (load) begin
      c_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      c_code <= b_code;
    end
  end

  // byte packer: one byte out per cycle while the output is free, next code loaded behind the last byte
  logic             out_free;
  logic             full;
  logic             pad;
  logic             emit;
  logic [CNT_W-1:0] rem;
  logic [BYTE_W-1:0] byte_out;
  logic             byte_last;
  logic [CNT_W-1:0] total_post;
  logic             flush_post;
  logic [ACC_W-1:0] acc_next;
  logic [CNT_W-1:0] total_next;
  logic             flush_next;

  always_comb begin
    out_free = !m_axis_tvalid || m_axis_tready;
    full     = total >= CNT_W'(BYTE_W);
    pad      = !full && flush && (total != '0);
    emit     = out_free && (full || pad);
    rem      = total - CNT_W'(BYTE_W);
    if (full) begin
      byte_out  = BYTE_W'(acc >> rem);
      byte_last = (rem < CNT_W'(BYTE_W)) && !(flush && (rem != '0));
    end else begin
      byte_out  = BYTE_W'(acc[BYTE_W-1:0] << (CNT_W'(BYTE_W) - total));
      byte_last = 1'b1;
    end
    if (emit) begin
      total_post = full ? rem : '0;
    end else begin
      total_post = total;
    end
    flush_post = flush && (total_post != '0);
    load       = c_valid && (total_post < CNT_W'(BYTE_W)) && !flush_post;
    if (load) begin
      acc_next   = (acc << c_code.len) | ACC_W'(c_code.bits);
      total_next = total_post + CNT_W'(c_code.len);
      flush_next = c_code.flush;
    end else begin
      acc_next   = acc;
      total_next = total_post;
      flush_next = flush_post;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      flush <= 1'b0;
    end else begin
      total <= total_next;
      flush <= flush_next;
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= byte_out;
      m_axis_tlast <= byte_last;
      m_axis_tuser <= pad;
    end
  end

  // checks
  a_pad_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("padded byte without last flag");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= CNT_W'(ACC_W))
    else $error("packer bit count overflow");

  a_stall_has_reason: assert property (@(posedge clk) disable iff (rst)
    (b_valid && !s_axis_tready) |-> c_valid)
    else $error("input stalled with empty code stage");

  a_load_clears_flush: assert property (@(posedge clk) disable iff (rst)
    load |-> !flush_post)
    else $error("code loaded while flush pending");

endmodule

`default_nettype wire
